### hdl/gdn_pkg.sv
// ----------------------------------------------------------------------------
// gdn_pkg
// Shared types, calendar constants and helpers for the Gregorian date and
// day number converter: micro-op codes, control word and condition flags.
// ----------------------------------------------------------------------------
package gdn_pkg;

    // calendar limits
    localparam int MAX_YEAR  = 9999;
    localparam int DAYS_400Y = 146097;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_4Y   = 1461;
    localparam int DAYS_1Y   = 365;

    // first day number past MAX_YEAR-12-31
    localparam int MAX_DAYS = MAX_YEAR * DAYS_1Y + MAX_YEAR / 4 - MAX_YEAR / 100
                              + MAX_YEAR / 400;

    // field widths
    localparam int NUM_W  = 22;
    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int ADDR_W = 5;
    localparam int PEEL_W = 4;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [PEEL_W-1:0] t_peel;

    // datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_YDIV,
        OP_YLEAP,
        OP_DCHK,
        OP_DP100,
        OP_DP400,
        OP_DADDQ,
        OP_DMON,
        OP_NCHK,
        OP_PEEL,
        OP_NMON,
        OP_NDAY,
        OP_FIN
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_FUNC1,
        C_DBAD,
        C_NBAD
    } t_cnd;

    typedef struct packed {
        t_op   op;
        t_cnd  cnd;
        t_addr target;
        t_peel peel;
    } t_cword;

    typedef struct packed {
        logic func1;
        logic date_bad;
        logic num_bad;
    } t_flags;

    // month lengths of a common year
    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // days before the first of each month in a common year
    localparam logic [8:0] CUM_BEFORE [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // restoring peel steps: span in days and the years it stands for
    localparam logic [NUM_W-1:0] PEEL_DAYS [16] = '{
        NUM_W'(DAYS_400Y * 16), NUM_W'(DAYS_400Y * 8), NUM_W'(DAYS_400Y * 4),
        NUM_W'(DAYS_400Y * 2), NUM_W'(DAYS_400Y),
        NUM_W'(DAYS_100Y * 2), NUM_W'(DAYS_100Y),
        NUM_W'(DAYS_4Y * 16), NUM_W'(DAYS_4Y * 8), NUM_W'(DAYS_4Y * 4),
        NUM_W'(DAYS_4Y * 2), NUM_W'(DAYS_4Y),
        NUM_W'(DAYS_1Y * 2), NUM_W'(DAYS_1Y),
        NUM_W'(0), NUM_W'(0)
    };

    localparam logic [YEAR_W-1:0] PEEL_YEARS [16] = '{
        14'd6400, 14'd3200, 14'd1600, 14'd800, 14'd400,
        14'd200, 14'd100,
        14'd64, 14'd32, 14'd16, 14'd8, 14'd4,
        14'd2, 14'd1,
        14'd0, 14'd0
    };

    // x / 100 by reciprocal, exact for x below 43699
    function automatic logic [7:0] div100(input logic [YEAR_W-1:0] x);
        logic [26:0] prod;
        prod = 27'(x) * 27'd5243;
        return prod[26:19];
    endfunction

endpackage

### hdl/gdn_useq.sv
// ----------------------------------------------------------------------------
// gdn_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module gdn_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  gdn_pkg::t_flags i_flags,
    output gdn_pkg::t_cword o_cw,
    output logic            o_busy
);

    localparam gdn_pkg::t_addr A_NUM = 5'd8;
    localparam gdn_pkg::t_addr A_FIN = 5'd27;

    logic           r_run;
    gdn_pkg::t_addr r_pc;
    gdn_pkg::t_cword w_rom;
    logic           w_jump;

    function automatic gdn_pkg::t_cword cw(input gdn_pkg::t_op op, input gdn_pkg::t_cnd cnd,
                                           input gdn_pkg::t_addr tgt,
                                           input gdn_pkg::t_peel idx);
        gdn_pkg::t_cword w;
        w.op     = op;
        w.cnd    = cnd;
        w.target = tgt;
        w.peel   = idx;
        return w;
    endfunction

    // control store
    always_comb begin
        unique case (r_pc)
            5'd0:  w_rom = cw(gdn_pkg::OP_NOP,   gdn_pkg::C_FUNC1,  A_NUM, 4'd0);
            5'd1:  w_rom = cw(gdn_pkg::OP_YDIV,  gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd2:  w_rom = cw(gdn_pkg::OP_YLEAP, gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd3:  w_rom = cw(gdn_pkg::OP_DCHK,  gdn_pkg::C_DBAD,   A_FIN, 4'd0);
            5'd4:  w_rom = cw(gdn_pkg::OP_DP100, gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd5:  w_rom = cw(gdn_pkg::OP_DP400, gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd6:  w_rom = cw(gdn_pkg::OP_DADDQ, gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd7:  w_rom = cw(gdn_pkg::OP_DMON,  gdn_pkg::C_ALWAYS, A_FIN, 4'd0);
            5'd8:  w_rom = cw(gdn_pkg::OP_NCHK,  gdn_pkg::C_NBAD,   A_FIN, 4'd0);
            5'd9:  w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd10: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd1);
            5'd11: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd2);
            5'd12: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd3);
            5'd13: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd4);
            5'd14: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd5);
            5'd15: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd6);
            5'd16: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd7);
            5'd17: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd8);
            5'd18: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd9);
            5'd19: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd10);
            5'd20: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd11);
            5'd21: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd12);
            5'd22: w_rom = cw(gdn_pkg::OP_PEEL,  gdn_pkg::C_NEXT,   A_FIN, 4'd13);
            5'd23: w_rom = cw(gdn_pkg::OP_YDIV,  gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd24: w_rom = cw(gdn_pkg::OP_YLEAP, gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd25: w_rom = cw(gdn_pkg::OP_NMON,  gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            5'd26: w_rom = cw(gdn_pkg::OP_NDAY,  gdn_pkg::C_NEXT,   A_FIN, 4'd0);
            default: w_rom = cw(gdn_pkg::OP_FIN, gdn_pkg::C_NEXT,   A_FIN, 4'd0);
        endcase
    end

    // jump decision
    always_comb begin
        case (w_rom.cnd)
            gdn_pkg::C_ALWAYS: w_jump = 1'b1;
            gdn_pkg::C_FUNC1:  w_jump = i_flags.func1;
            gdn_pkg::C_DBAD:   w_jump = i_flags.date_bad;
            gdn_pkg::C_NBAD:   w_jump = i_flags.num_bad;
            default:           w_jump = 1'b0;
        endcase
    end

    // idle sequencer issues no-ops
    always_comb begin
        o_cw = w_rom;
        if (!r_run) begin
            o_cw.op = gdn_pkg::OP_NOP;
        end
    end

    assign o_busy = r_run;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
        end else if (i_go) begin
            r_run <= 1'b1;
            r_pc  <= '0;
        end else if (r_run) begin
            if (w_rom.op == gdn_pkg::OP_FIN) begin
                r_run <= 1'b0;
            end else if (w_jump) begin
                r_pc <= w_rom.target;
            end else begin
                r_pc <= r_pc + 5'd1;
            end
        end
    end

endmodule

### hdl/gregorian_day_number_converter_top.sv
// ----------------------------------------------------------------------------
// gregorian_day_number_converter_top
// Proleptic Gregorian date to day number and back, microcoded datapath.
// ----------------------------------------------------------------------------
// A start beat is taken while busy is low. Date to number runs 9 sequencer
// steps (5 for a rejected date); number to date runs 21 steps (3 for a number
// past the last day), most of them the fourteen restoring subtraction steps
// that peel 400, 100, 4 and 1 year spans off the day number. The result shows
// on the o_ ports for one cycle with o_strobe, in the cycle after the last step;
// the receiver cannot stall it. busy drops as the strobe rises, so the next
// start may be given in the strobe cycle. Invalid input gives all zeros with
// o_valid_res low. No clearing pass follows reset.
module gregorian_day_number_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [21:0] i_day_number,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    output logic        o_strobe,
    output logic [21:0] o_number_out,
    output logic [13:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic        o_leap_out,
    output logic        o_valid_res
);

    logic                        w_go;
    gdn_pkg::t_cword             w_cw;
    gdn_pkg::t_flags             w_flags;

    // working registers
    logic                        r_func;
    logic [gdn_pkg::NUM_W-1:0]   r_num;
    logic [gdn_pkg::NUM_W-1:0]   r_t;
    logic [gdn_pkg::YEAR_W-1:0]  r_y;
    logic [gdn_pkg::MON_W-1:0]   r_m;
    logic [gdn_pkg::DAY_W-1:0]   r_d;
    logic [7:0]                  r_q;
    logic                        r_leap;
    logic                        r_ok;

    // result registers
    logic                        r_strobe;
    logic [gdn_pkg::NUM_W-1:0]   r_num_o;
    logic [gdn_pkg::YEAR_W-1:0]  r_y_o;
    logic [gdn_pkg::MON_W-1:0]   r_m_o;
    logic [gdn_pkg::DAY_W-1:0]   r_d_o;
    logic                        r_leap_o;
    logic                        r_ok_o;

    logic [gdn_pkg::YEAR_W-1:0]  w_p;
    logic [gdn_pkg::YEAR_W-1:0]  w_hund;
    logic                        w_m_ok;
    logic [3:0]                  w_midx;
    logic                        w_adj;
    logic [gdn_pkg::DAY_W:0]     w_mlen;
    logic                        w_date_ok;
    logic                        w_num_ok;
    logic [gdn_pkg::NUM_W-1:0]   w_peel_days;
    logic [3:0]                  w_mcount;
    logic [8:0]                  w_doy_base;

    assign w_go = start && !busy;

    gdn_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_flags (w_flags),
        .o_cw    (w_cw),
        .o_busy  (busy)
    );

    // year arithmetic
    assign w_p    = r_y - 14'd1;
    assign w_hund = 14'(r_q) * 14'd100;

    // month lookup with leap correction past february
    assign w_m_ok = (r_m >= 4'd1) && (r_m <= 4'd12);
    assign w_midx = w_m_ok ? (r_m - 4'd1) : 4'd0;
    assign w_adj  = r_leap && (r_m > 4'd2);
    assign w_mlen = 6'(gdn_pkg::MONTH_LEN[w_midx]) + 6'(r_leap && (r_m == 4'd2));
    assign w_doy_base = gdn_pkg::CUM_BEFORE[w_midx] + 9'(w_adj);

    // input range checks
    assign w_date_ok = (r_y >= 14'd1) && (r_y <= 14'(gdn_pkg::MAX_YEAR)) && w_m_ok
                       && (r_d >= 5'd1) && (6'(r_d) <= w_mlen);
    assign w_num_ok  = r_num < 22'(gdn_pkg::MAX_DAYS);

    assign w_flags.func1    = r_func;
    assign w_flags.date_bad = !w_date_ok;
    assign w_flags.num_bad  = !w_num_ok;

    assign w_peel_days = gdn_pkg::PEEL_DAYS[w_cw.peel];

    // month of the day of year: count month ends already passed
    always_comb begin
        w_mcount = 4'd1;
        for (int j = 1; j < 12; j++) begin
            if (r_t[8:0] >= (gdn_pkg::CUM_BEFORE[j] + 9'(r_leap && (j >= 2)))) begin
                w_mcount = w_mcount + 4'd1;
            end
        end
    end

    // datapath driven by the control word
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_func <= i_func;
            r_num  <= i_day_number;
            r_y    <= i_year;
            r_m    <= i_month;
            r_d    <= i_day;
        end else begin
            case (w_cw.op)
                gdn_pkg::OP_YDIV: begin
                    r_q <= gdn_pkg::div100(r_y);
                end
                gdn_pkg::OP_YLEAP: begin
                    r_leap <= (r_y == w_hund) ? (r_q[1:0] == 2'd0) : (r_y[1:0] == 2'd0);
                end
                gdn_pkg::OP_DCHK: begin
                    r_ok <= w_date_ok;
                end
                gdn_pkg::OP_DP100: begin
                    r_q   <= gdn_pkg::div100(w_p);
                    r_num <= 22'(w_p) * 22'(gdn_pkg::DAYS_1Y);
                end
                gdn_pkg::OP_DP400: begin
                    r_q   <= gdn_pkg::div100({2'b00, w_p[13:2]});
                    r_num <= r_num + 22'(w_p[13:2]) - 22'(r_q);
                end
                gdn_pkg::OP_DADDQ: begin
                    r_num <= r_num + 22'(r_q);
                end
                gdn_pkg::OP_DMON: begin
                    r_num <= r_num + 22'(w_doy_base) + 22'(r_d) - 22'd1;
                end
                gdn_pkg::OP_NCHK: begin
                    r_ok <= w_num_ok;
                    r_t  <= r_num;
                    r_y  <= 14'd1;
                end
                gdn_pkg::OP_PEEL: begin
                    if (r_t >= w_peel_days) begin
                        r_t <= r_t - w_peel_days;
                        r_y <= r_y + gdn_pkg::PEEL_YEARS[w_cw.peel];
                    end
                end
                gdn_pkg::OP_NMON: begin
                    r_m <= w_mcount;
                end
                gdn_pkg::OP_NDAY: begin
                    r_d <= 5'(r_t[8:0] - w_doy_base + 9'd1);
                end
                default: begin
                end
            endcase
        end
    end

    // result beat, zeroed when invalid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (w_cw.op == gdn_pkg::OP_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw.op == gdn_pkg::OP_FIN) begin
            r_num_o  <= r_ok ? r_num : '0;
            r_y_o    <= r_ok ? r_y : '0;
            r_m_o    <= r_ok ? r_m : '0;
            r_d_o    <= r_ok ? r_d : '0;
            r_leap_o <= r_ok && r_leap;
            r_ok_o   <= r_ok;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_number_out = r_num_o;
    assign o_year_out   = r_y_o;
    assign o_month_out  = r_m_o;
    assign o_day_out    = r_d_o;
    assign o_leap_out   = r_leap_o;
    assign o_valid_res  = r_ok_o;

    // checks
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while sequencer busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted start did not raise busy");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |-> (o_number_out == 22'd0 && o_year_out == 14'd0
            && o_month_out == 4'd0 && o_day_out == 5'd0 && !o_leap_out))
        else $error("invalid result not cleared");

    a_valid_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res) |-> (o_month_out >= 4'd1 && o_month_out <= 4'd12
            && o_day_out >= 5'd1 && o_year_out >= 14'd1))
        else $error("valid result carries an impossible date");

endmodule
